[rtl/core/held_input_state_tracker_unit_defines.svh]
// assertion macros shared by the tracker rtl
`ifndef HELD_INPUT_STATE_TRACKER_UNIT_DEFINES_SVH
`define HELD_INPUT_STATE_TRACKER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define HIST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition in one cycle implies property in the next
`define HIST_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define HIST_ASSERT(lbl, clk, rst, prop, msg)
`define HIST_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg)
`endif
`endif

[rtl/core/hist_pkg.sv]
package hist_pkg;

   localparam int CODE_BITS  = 25;
   localparam int STATE_BITS = 3;
   localparam int OP_BITS    = 3;

   // command codes
   localparam logic [OP_BITS-1:0] CMD_PRESS   = 3'd0;
   localparam logic [OP_BITS-1:0] CMD_RELEASE = 3'd1;
   localparam logic [OP_BITS-1:0] CMD_TICK    = 3'd2;
   localparam logic [OP_BITS-1:0] CMD_QUERY   = 3'd3;
   localparam logic [OP_BITS-1:0] CMD_CLEAR   = 3'd4;

   // per-entry state codes
   localparam logic [STATE_BITS-1:0] ST_INVALID      = 3'd0;
   localparam logic [STATE_BITS-1:0] ST_REGISTERED   = 3'd1;
   localparam logic [STATE_BITS-1:0] ST_TRIGGERED    = 3'd2;
   localparam logic [STATE_BITS-1:0] ST_PRESSED      = 3'd3;
   localparam logic [STATE_BITS-1:0] ST_UNREGISTERED = 3'd4;
   localparam logic [STATE_BITS-1:0] ST_RELEASED     = 3'd5;

   // datapath actions issued by the controller
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_SCAN_INIT,
      ACT_TICK_INIT,
      ACT_CLEAR,
      ACT_READ,
      ACT_SCAN_CMP,
      ACT_SCAN_APPLY,
      ACT_TICK_MOVE,
      ACT_TICK_TBL_END,
      ACT_RESULT
   } hist_act_type;

   typedef struct packed {
      logic         in_ready;
      hist_act_type act;
   } hist_cmd_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               hit;
      logic               scan_end;
      logic               on_key;
      logic               out_free;
   } hist_status_type;

   // state advance applied on a frame tick
   function automatic logic [STATE_BITS-1:0] adv_state(input logic [STATE_BITS-1:0] s);
      logic [STATE_BITS-1:0] r;
      r = s;
      case (s)
         ST_REGISTERED:   r = ST_TRIGGERED;
         ST_TRIGGERED:    r = ST_PRESSED;
         ST_UNREGISTERED: r = ST_RELEASED;
         default:         r = s;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/held_input_state_tracker_unit.sv]
// channel   direction  tdata (low bit up)                      tuser
// req       in         code, cursor_x, cursor_y, zero pad      command, device
// rsp       out        code_state, delta_x, delta_y, zero pad  table_full
//
// one transaction at a time; the next request can be taken in the cycle after a result loads
// press, release, query: read and compare entries one at a time until a hit or the table end, then apply
// frame tick: compacts buttons then keys, one ram read and write step per entry
// clear and unused commands: go straight to the result
// synchronous active-high reset empties both tables and zeroes the cursor state
// a stalled rsp holds its result; the next result waits in the datapath while the controller holds
module held_input_state_tracker_unit import hist_pkg::*; #(
   parameter int KEY_SLOTS     = 16,
   parameter int BUTTON_SLOTS  = 8,
   parameter int POSITION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // code, cursor_x, cursor_y, zero pad
   input  logic [((CODE_BITS + 2*POSITION_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // command, device
   input  logic [OP_BITS:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // code_state, delta_x, delta_y, zero pad
   output logic [((STATE_BITS + 2*(POSITION_BITS + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // table_full
   output logic rsp_tuser
);

   localparam int P        = POSITION_BITS;
   localparam int OUT_USED = STATE_BITS + 2*(P + 1);
   localparam int OUT_BITS = ((OUT_USED + 7) / 8) * 8;
   localparam int OUT_PAD  = OUT_BITS - OUT_USED;

   hist_cmd_type          ctl_cmd;
   hist_status_type       dp_status;
   logic [STATE_BITS-1:0] code_state;
   logic [P:0]            delta_x;
   logic [P:0]            delta_y;

   hist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (dp_status),
      .cmd        (ctl_cmd)
   );

   hist_datapath #(
      .KEY_SLOTS     (KEY_SLOTS),
      .BUTTON_SLOTS  (BUTTON_SLOTS),
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctl_cmd),
      .status         (dp_status),
      .in_command     (req_tuser[OP_BITS-1:0]),
      .in_device      (req_tuser[OP_BITS]),
      .in_code        (req_tdata[CODE_BITS-1:0]),
      .in_cursor_x    (req_tdata[CODE_BITS +: P]),
      .in_cursor_y    (req_tdata[CODE_BITS + P +: P]),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_code_state (code_state),
      .out_delta_x    (delta_x),
      .out_delta_y    (delta_y),
      .out_table_full (rsp_tuser)
   );

   assign req_tready = ctl_cmd.in_ready;
   assign rsp_tdata  = {{OUT_PAD{1'b0}}, delta_y, delta_x, code_state};

endmodule

[rtl/core/hist_ram.sv]
module hist_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/core/hist_ctrl.sv]
`include "held_input_state_tracker_unit_defines.svh"

module hist_ctrl import hist_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  hist_status_type status,
   output hist_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SCAN_END,
      S_TICK_RD,
      S_TICK_CHK,
      S_RESULT
   } state_type;

   state_type    state_ff, state_in;
   logic         ready_ff, ready_in;
   hist_act_type act;

   // next state and action decode
   always_comb begin
      act      = ACT_NONE;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               act      = ACT_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (status.op) inside
               CMD_PRESS, CMD_RELEASE, CMD_QUERY: begin
                  act      = ACT_SCAN_INIT;
                  state_in = S_SCAN_RD;
               end
               CMD_TICK: begin
                  act      = ACT_TICK_INIT;
                  state_in = S_TICK_RD;
               end
               CMD_CLEAR: begin
                  act      = ACT_CLEAR;
                  state_in = S_RESULT;
               end
               default: begin
                  state_in = S_RESULT;
               end
            endcase
         end
         S_SCAN_RD: begin
            if (status.scan_end) begin
               state_in = S_SCAN_END;
            end else begin
               act      = ACT_READ;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            act      = ACT_SCAN_CMP;
            state_in = status.hit ? S_SCAN_END : S_SCAN_RD;
         end
         S_SCAN_END: begin
            act      = ACT_SCAN_APPLY;
            state_in = S_RESULT;
         end
         S_TICK_RD: begin
            if (status.scan_end) begin
               act      = ACT_TICK_TBL_END;
               state_in = status.on_key ? S_RESULT : S_TICK_RD;
            end else begin
               act      = ACT_READ;
               state_in = S_TICK_CHK;
            end
         end
         S_TICK_CHK: begin
            act      = ACT_TICK_MOVE;
            state_in = S_TICK_RD;
         end
         S_RESULT: begin
            act = ACT_RESULT;
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      ready_in = (state_in == S_IDLE);
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign cmd.in_ready = ready_ff;
   assign cmd.act      = act;

   `HIST_ASSERT_NEXT(a_accept_drops_ready, clock, reset, req_tvalid && ready_ff, !ready_ff, "ready stayed high after a transaction was accepted")

endmodule

[rtl/core/hist_datapath.sv]
`include "held_input_state_tracker_unit_defines.svh"

module hist_datapath import hist_pkg::*; #(
   parameter int KEY_SLOTS     = 16,
   parameter int BUTTON_SLOTS  = 8,
   parameter int POSITION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hist_cmd_type             cmd,
   output hist_status_type          status,
   input  logic [OP_BITS-1:0]       in_command,
   input  logic                     in_device,
   input  logic [CODE_BITS-1:0]     in_code,
   input  logic [POSITION_BITS-1:0] in_cursor_x,
   input  logic [POSITION_BITS-1:0] in_cursor_y,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [STATE_BITS-1:0]    out_code_state,
   output logic [POSITION_BITS:0]   out_delta_x,
   output logic [POSITION_BITS:0]   out_delta_y,
   output logic                     out_table_full
);

   localparam int KCW        = $clog2(KEY_SLOTS + 1);
   localparam int BCW        = $clog2(BUTTON_SLOTS + 1);
   localparam int IW         = (KCW > BCW) ? KCW : BCW;
   localparam int KAW        = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int BAW        = (BUTTON_SLOTS > 1) ? $clog2(BUTTON_SLOTS) : 1;
   localparam int ENTRY_BITS = CODE_BITS + STATE_BITS;
   localparam int P          = POSITION_BITS;

   // latched transaction
   logic [OP_BITS-1:0]   op_ff, op_in;
   logic                 dev_ff, dev_in;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic [P-1:0]         cx_ff, cx_in;
   logic [P-1:0]         cy_ff, cy_in;

   // table bookkeeping
   logic [KCW-1:0]        key_count_ff, key_count_in;
   logic [BCW-1:0]        btn_count_ff, btn_count_in;
   logic [IW-1:0]         i_ff, i_in;
   logic [IW-1:0]         w_ff, w_in;
   logic                  tbl_ff, tbl_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         fidx_ff, fidx_in;
   logic [STATE_BITS-1:0] fstate_ff, fstate_in;

   // cursor tracking
   logic [P-1:0] last_x_ff, last_x_in;
   logic [P-1:0] last_y_ff, last_y_in;
   logic [P:0]   move_x_ff, move_x_in;
   logic [P:0]   move_y_ff, move_y_in;

   // pending result and output register
   logic [STATE_BITS-1:0] res_state_ff, res_state_in;
   logic                  res_full_ff, res_full_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATE_BITS-1:0] rsp_state_ff, rsp_state_in;
   logic [P:0]            rsp_dx_ff, rsp_dx_in;
   logic [P:0]            rsp_dy_ff, rsp_dy_in;
   logic                  rsp_full_ff, rsp_full_in;

   // memory ports
   logic                  wr_en;
   logic [IW-1:0]         wr_idx;
   logic [ENTRY_BITS-1:0] wr_entry;
   logic                  rd_en;
   logic [ENTRY_BITS-1:0] key_rd, btn_rd, rd_entry;
   logic [CODE_BITS-1:0]  rd_code;
   logic [STATE_BITS-1:0] rd_state;
   logic [IW-1:0]         cnt_sel;
   logic [IW-1:0]         slots_sel;
   logic                  hit;
   logic                  out_free;

   hist_ram #(.WIDTH(ENTRY_BITS), .DEPTH(KEY_SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en && !tbl_ff),
      .wr_addr (wr_idx[KAW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (i_ff[KAW-1:0]),
      .rd_data (key_rd)
   );

   hist_ram #(.WIDTH(ENTRY_BITS), .DEPTH(BUTTON_SLOTS)) u_btn_ram (
      .clock   (clock),
      .wr_en   (wr_en && tbl_ff),
      .wr_addr (wr_idx[BAW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (i_ff[BAW-1:0]),
      .rd_data (btn_rd)
   );

   // selected table view
   assign rd_entry  = tbl_ff ? btn_rd : key_rd;
   assign rd_code   = rd_entry[CODE_BITS-1:0];
   assign rd_state  = rd_entry[ENTRY_BITS-1 -: STATE_BITS];
   assign cnt_sel   = tbl_ff ? IW'(btn_count_ff) : IW'(key_count_ff);
   assign slots_sel = tbl_ff ? IW'(BUTTON_SLOTS) : IW'(KEY_SLOTS);
   assign hit       = (rd_code == code_ff);
   assign out_free  = !rsp_valid_ff || out_ready;
   assign rd_en     = (cmd.act == ACT_READ);

   // next-state logic per controller action
   always_comb begin
      op_in        = op_ff;
      dev_in       = dev_ff;
      code_in      = code_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      key_count_in = key_count_ff;
      btn_count_in = btn_count_ff;
      i_in         = i_ff;
      w_in         = w_ff;
      tbl_in       = tbl_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      fstate_in    = fstate_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      move_x_in    = move_x_ff;
      move_y_in    = move_y_ff;
      res_state_in = res_state_ff;
      res_full_in  = res_full_ff;
      rsp_state_in = rsp_state_ff;
      rsp_dx_in    = rsp_dx_ff;
      rsp_dy_in    = rsp_dy_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      wr_en        = 1'b0;
      wr_idx       = w_ff;
      wr_entry     = {rd_state, rd_code};
      case (cmd.act)
         ACT_LOAD: begin
            op_in        = in_command;
            dev_in       = in_device;
            code_in      = in_code;
            cx_in        = in_cursor_x;
            cy_in        = in_cursor_y;
            res_state_in = ST_INVALID;
            res_full_in  = 1'b0;
         end
         ACT_SCAN_INIT: begin
            i_in     = '0;
            w_in     = '0;
            tbl_in   = dev_ff;
            found_in = 1'b0;
         end
         ACT_TICK_INIT: begin
            // buttons are compacted first, then keys
            i_in      = '0;
            w_in      = '0;
            tbl_in    = 1'b1;
            move_x_in = {cx_ff[P-1], cx_ff} - {last_x_ff[P-1], last_x_ff};
            move_y_in = {cy_ff[P-1], cy_ff} - {last_y_ff[P-1], last_y_ff};
            last_x_in = cx_ff;
            last_y_in = cy_ff;
         end
         ACT_CLEAR: begin
            key_count_in = '0;
            btn_count_in = '0;
         end
         ACT_SCAN_CMP: begin
            if (hit) begin
               found_in  = 1'b1;
               fidx_in   = i_ff;
               fstate_in = rd_state;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ACT_SCAN_APPLY: begin
            if (op_ff == CMD_PRESS) begin
               if (found_ff) begin
                  res_state_in = fstate_ff;
               end else if (cnt_sel < slots_sel) begin
                  // append as registered at the end of the table
                  wr_en        = 1'b1;
                  wr_idx       = cnt_sel;
                  wr_entry     = {ST_REGISTERED, code_ff};
                  res_state_in = ST_REGISTERED;
                  if (tbl_ff) begin
                     btn_count_in = btn_count_ff + 1'b1;
                  end else begin
                     key_count_in = key_count_ff + 1'b1;
                  end
               end else begin
                  res_full_in = 1'b1;
               end
            end else if (op_ff == CMD_RELEASE) begin
               if (found_ff) begin
                  wr_en        = 1'b1;
                  wr_idx       = fidx_ff;
                  wr_entry     = {ST_UNREGISTERED, code_ff};
                  res_state_in = ST_UNREGISTERED;
               end
            end else begin
               res_state_in = found_ff ? fstate_ff : ST_INVALID;
            end
         end
         ACT_TICK_MOVE: begin
            // keep non-released entries in order with their advanced state
            if (rd_state != ST_RELEASED) begin
               wr_en    = 1'b1;
               wr_idx   = w_ff;
               wr_entry = {adv_state(rd_state), rd_code};
               w_in     = w_ff + 1'b1;
            end
            i_in = i_ff + 1'b1;
         end
         ACT_TICK_TBL_END: begin
            if (tbl_ff) begin
               btn_count_in = w_ff[BCW-1:0];
               tbl_in       = 1'b0;
               i_in         = '0;
               w_in         = '0;
            end else begin
               key_count_in = w_ff[KCW-1:0];
            end
         end
         ACT_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = res_state_ff;
               rsp_dx_in    = move_x_ff;
               rsp_dy_in    = move_y_ff;
               rsp_full_in  = res_full_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         btn_count_ff <= '0;
         i_ff         <= '0;
         w_ff         <= '0;
         tbl_ff       <= 1'b0;
         found_ff     <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         move_x_ff    <= '0;
         move_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_count_ff <= key_count_in;
         btn_count_ff <= btn_count_in;
         i_ff         <= i_in;
         w_ff         <= w_in;
         tbl_ff       <= tbl_in;
         found_ff     <= found_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         move_x_ff    <= move_x_in;
         move_y_ff    <= move_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      dev_ff       <= dev_in;
      code_ff      <= code_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      fidx_ff      <= fidx_in;
      fstate_ff    <= fstate_in;
      res_state_ff <= res_state_in;
      res_full_ff  <= res_full_in;
      rsp_state_ff <= rsp_state_in;
      rsp_dx_ff    <= rsp_dx_in;
      rsp_dy_ff    <= rsp_dy_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign status.op       = op_ff;
   assign status.hit      = hit;
   assign status.scan_end = (i_ff == cnt_sel);
   assign status.on_key   = !tbl_ff;
   assign status.out_free = out_free;

   assign out_valid      = rsp_valid_ff;
   assign out_code_state = rsp_state_ff;
   assign out_delta_x    = rsp_dx_ff;
   assign out_delta_y    = rsp_dy_ff;
   assign out_table_full = rsp_full_ff;

   `HIST_ASSERT(a_key_count_max, clock, reset, key_count_ff <= KEY_SLOTS, "key table count beyond its slots")
   `HIST_ASSERT(a_btn_count_max, clock, reset, btn_count_ff <= BUTTON_SLOTS, "button table count beyond its slots")
   `HIST_ASSERT(a_write_behind_read, clock, reset, w_ff <= i_ff, "compaction write index passed the read index")
   `HIST_ASSERT_NEXT(a_result_loads, clock, reset, cmd.act == ACT_RESULT && out_free, rsp_valid_ff, "result was not loaded into the output register")

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench import hist_pkg::*;;

   localparam int KEY_SLOTS     = 16;
   localparam int BUTTON_SLOTS  = 8;
   localparam int POS_BITS      = 16;
   localparam int KEY_POOL      = 24;
   localparam int BUTTON_POOL   = 12;
   localparam int RANDOM_ITEMS  = 1150;
   localparam int CALM_ITEMS    = 100;
   localparam int HOLD_AT_ITEM  = 400;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 80;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_LINES  = 100;

   // commands the block does not define, expected to do nothing
   localparam logic [OP_BITS-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [OP_BITS-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [OP_BITS-1:0] CMD_SPARE_7 = 3'd7;

   // table select
   localparam logic DEV_KEY    = 1'b0;
   localparam logic DEV_BUTTON = 1'b1;

   localparam logic [CODE_BITS-1:0] CODE_LO = '0;
   localparam logic [CODE_BITS-1:0] CODE_HI = '1;
   localparam logic [POS_BITS-1:0]  POS_MIN = 16'h8000;
   localparam logic [POS_BITS-1:0]  POS_MAX = 16'h7fff;
   localparam logic [POS_BITS-1:0]  POS_ZERO = '0;

   typedef struct {
      logic [STATE_BITS-1:0] code_state;
      logic [POS_BITS:0]     delta_x;
      logic [POS_BITS:0]     delta_y;
      logic                  table_full;
   } tracker_result_type;

   // tracks both held-code tables and the cursor, and checks each result
   class tracker_scoreboard;
      logic [CODE_BITS-1:0]  held_code  [2][KEY_SLOTS];
      logic [STATE_BITS-1:0] held_state [2][KEY_SLOTS];
      int                    held_count [2];
      logic [POS_BITS-1:0]   last_x;
      logic [POS_BITS-1:0]   last_y;
      logic [POS_BITS:0]     move_x;
      logic [POS_BITS:0]     move_y;
      tracker_result_type    expected_q [$];
      int                    mismatches;

      function new();
         held_count[0] = 0;
         held_count[1] = 0;
         last_x = '0;
         last_y = '0;
         move_x = '0;
         move_y = '0;
         mismatches = 0;
      endfunction

      function int find_slot(logic dev, logic [CODE_BITS-1:0] code);
         for (int i = 0; i < held_count[dev]; i++)
            if (held_code[dev][i] == code) return i;
         return -1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // apply one accepted request transaction and queue its result
      function void note_request(logic [OP_BITS-1:0] cmd, logic dev,
                                 logic [CODE_BITS-1:0] code,
                                 logic [POS_BITS-1:0] x, logic [POS_BITS-1:0] y);
         tracker_result_type r;
         int slot;
         int slots;
         int w;
         r.code_state = ST_INVALID;
         r.table_full = 1'b0;
         slots = (dev == DEV_BUTTON) ? BUTTON_SLOTS : KEY_SLOTS;
         slot = find_slot(dev, code);
         case (cmd)
            CMD_PRESS: begin
               if (slot >= 0) begin
                  r.code_state = held_state[dev][slot];
               end else if (held_count[dev] < slots) begin
                  held_code[dev][held_count[dev]] = code;
                  held_state[dev][held_count[dev]] = ST_REGISTERED;
                  held_count[dev]++;
                  r.code_state = ST_REGISTERED;
               end else begin
                  r.table_full = 1'b1;
               end
            end
            CMD_RELEASE: begin
               if (slot >= 0) begin
                  held_state[dev][slot] = ST_UNREGISTERED;
                  r.code_state = ST_UNREGISTERED;
               end
            end
            CMD_TICK: begin
               move_x = {x[POS_BITS-1], x} - {last_x[POS_BITS-1], last_x};
               move_y = {y[POS_BITS-1], y} - {last_y[POS_BITS-1], last_y};
               last_x = x;
               last_y = y;
               // drop released entries in order, advance the survivors
               for (int t = 0; t < 2; t++) begin
                  w = 0;
                  for (int i = 0; i < held_count[t]; i++) begin
                     if (held_state[t][i] != ST_RELEASED) begin
                        held_code[t][w] = held_code[t][i];
                        case (held_state[t][i])
                           ST_REGISTERED:   held_state[t][w] = ST_TRIGGERED;
                           ST_TRIGGERED:    held_state[t][w] = ST_PRESSED;
                           ST_UNREGISTERED: held_state[t][w] = ST_RELEASED;
                           default:         held_state[t][w] = held_state[t][i];
                        endcase
                        w++;
                     end
                  end
                  held_count[t] = w;
               end
            end
            CMD_QUERY: begin
               if (slot >= 0) r.code_state = held_state[dev][slot];
            end
            CMD_CLEAR: begin
               held_count[0] = 0;
               held_count[1] = 0;
            end
            default: ;
         endcase
         r.delta_x = move_x;
         r.delta_y = move_y;
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string msg);
         if (mismatches < REPORT_LINES) $display("%0t mismatch: %s", $time, msg);
         mismatches++;
      endtask

      // compare one accepted response transaction with the oldest expectation
      task check_response(logic [STATE_BITS-1:0] st, logic [POS_BITS:0] dx,
                          logic [POS_BITS:0] dy, logic full);
         tracker_result_type r;
         if (expected_q.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            r = expected_q.pop_front();
            if (st !== r.code_state)
               report_mismatch($sformatf("code_state got %0d want %0d", st, r.code_state));
            if (dx !== r.delta_x)
               report_mismatch($sformatf("delta_x got %0d want %0d",
                                         $signed(dx), $signed(r.delta_x)));
            if (dy !== r.delta_y)
               report_mismatch($sformatf("delta_y got %0d want %0d",
                                         $signed(dy), $signed(r.delta_y)));
            if (full !== r.table_full)
               report_mismatch($sformatf("table_full got %0b want %0b", full, r.table_full));
         end
      endtask
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [3:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;

   // no idling once set; hold request for the long response stall
   bit calm     = 1'b0;
   bit hold_rsp = 1'b0;

   tracker_scoreboard sb = new();

   logic [CODE_BITS-1:0] key_pool    [KEY_POOL];
   logic [CODE_BITS-1:0] button_pool [BUTTON_POOL];
   logic [OP_BITS-1:0]   spare_cmd   [3] = '{CMD_SPARE_5, CMD_SPARE_6, CMD_SPARE_7};

   held_input_state_tracker_unit #(
      .KEY_SLOTS(KEY_SLOTS),
      .BUTTON_SLOTS(BUTTON_SLOTS),
      .POSITION_BITS(POS_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // offer one request transaction, possibly after an idle burst
   task automatic send_item(logic [OP_BITS-1:0] cmd, logic dev, logic [CODE_BITS-1:0] code,
                            logic [POS_BITS-1:0] x, logic [POS_BITS-1:0] y);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, y, x, code};
      req_tuser  <= {dev, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, dev, code, x, y);
   endtask

   // a pool code most of the time so presses, releases and queries hit
   task automatic send_random_item();
      int pick;
      logic dev;
      logic [OP_BITS-1:0] cmd;
      logic [CODE_BITS-1:0] code;
      pick = $urandom_range(0, 199);
      dev  = 1'($urandom_range(0, 1));
      if (pick < 72)       cmd = CMD_PRESS;
      else if (pick < 112) cmd = CMD_RELEASE;
      else if (pick < 140) cmd = CMD_TICK;
      else if (pick < 193) cmd = CMD_QUERY;
      else if (pick < 196) cmd = CMD_CLEAR;
      else                 cmd = spare_cmd[$urandom_range(0, 2)];
      if ($urandom_range(0, 9) == 0)
         code = CODE_BITS'($urandom());
      else if (dev == DEV_BUTTON)
         code = button_pool[$urandom_range(0, BUTTON_POOL - 1)];
      else
         code = key_pool[$urandom_range(0, KEY_POOL - 1)];
      send_item(cmd, dev, code, POS_BITS'($urandom()), POS_BITS'($urandom()));
   endtask

   // response side: monitor, random stalls and one long hold-off
   initial begin : rsp_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[2:0], rsp_tdata[19:3], rsp_tdata[36:20], rsp_tuser);
         if (hold_rsp) begin
            hold_left = HOLD_CYCLES;
            hold_rsp  = 1'b0;
         end
         if (hold_left > 0) hold_left--;
         else if (stall_left > 0) stall_left--;
         else if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 13);
         rsp_tready <= (hold_left == 0 && stall_left == 0);
      end
   end

   initial begin : stimulus
      for (int i = 0; i < KEY_POOL; i++)
         key_pool[i] = CODE_BITS'(($urandom() << 5) | i);
      for (int i = 0; i < BUTTON_POOL; i++)
         button_pool[i] = CODE_BITS'(($urandom() << 5) | i);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: code extremes, every command and state path
      send_item(CMD_CLEAR,   DEV_KEY,    CODE_LO, POS_ZERO, POS_ZERO);
      send_item(CMD_PRESS,   DEV_KEY,    CODE_LO, POS_ZERO, POS_ZERO);
      send_item(CMD_PRESS,   DEV_KEY,    CODE_HI, POS_ZERO, POS_ZERO);
      send_item(CMD_PRESS,   DEV_KEY,    CODE_LO, POS_ZERO, POS_ZERO);
      send_item(CMD_QUERY,   DEV_KEY,    CODE_HI, POS_ZERO, POS_ZERO);
      send_item(CMD_RELEASE, DEV_KEY,    CODE_LO, POS_ZERO, POS_ZERO);
      send_item(CMD_RELEASE, DEV_KEY,    key_pool[0], POS_ZERO, POS_ZERO);
      send_item(CMD_QUERY,   DEV_BUTTON, CODE_HI, POS_ZERO, POS_ZERO);
      send_item(CMD_TICK,    DEV_KEY,    CODE_LO, POS_MIN, POS_MAX);
      send_item(CMD_TICK,    DEV_BUTTON, CODE_HI, POS_MAX, POS_MIN);
      send_item(CMD_RELEASE, DEV_KEY,    CODE_HI, POS_ZERO, POS_ZERO);
      // fill the button table and overflow it by one
      for (int i = 0; i <= BUTTON_SLOTS; i++)
         send_item(CMD_PRESS, DEV_BUTTON, button_pool[i], POS_ZERO, POS_ZERO);
      send_item(CMD_QUERY,   DEV_BUTTON, button_pool[0], POS_ZERO, POS_ZERO);
      for (int i = 0; i < 3; i++)
         send_item(spare_cmd[i], DEV_KEY, CODE_HI, POS_MAX, POS_MAX);
      send_item(CMD_CLEAR,   DEV_BUTTON, CODE_LO, POS_ZERO, POS_ZERO);

      // random traffic
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == HOLD_AT_ITEM) hold_rsp = 1'b1;
         if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         send_random_item();
      end
      req_tvalid <= 1'b0;

      // drain
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
